// File: rtl/bda_pkg.sv
`default_nettype none

package bda_pkg;

   // default width of the converted value
   localparam int VALUE_WIDTH_DEFAULT = 64;

   // ASCII codes
   localparam logic [7:0] CHAR_PREFIX = 8'h72;   // 'r'
   localparam logic [7:0] CHAR_ZERO   = 8'h30;   // '0'

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_PREFIX,
      ST_DIGIT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic convert;
      logic skip;
      logic emit_prefix;
      logic emit_digit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic conv_done;
      logic top_zero;
      logic one_left;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/bda_datapath.sv
`default_nettype none

module bda_datapath #(
   parameter int VALUE_WIDTH = bda_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire [63:0]            req_value,
   input  bda_pkg::cmd_type      cmd,
   output bda_pkg::status_type   sts,
   output logic                  rsp_strobe,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_last_char
);

   localparam int NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int CNT_W      = $clog2(VALUE_WIDTH);
   localparam int REM_W      = $clog2(NUM_DIGITS + 1);

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [7:0]             char_ff, char_in;
   logic                   last_ff, last_in;
   logic                   strobe_ff, strobe_in;
   logic [3:0]             top_digit;

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // next values of the working registers
   always_comb begin
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      strobe_in = 1'b0;
      if (cmd.load) begin
         bin_in = req_value[VALUE_WIDTH-1:0];
         bcd_in = '0;
         cnt_in = CNT_W'(VALUE_WIDTH - 1);
         rem_in = REM_W'(NUM_DIGITS);
      end
      if (cmd.convert) begin
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.skip || cmd.emit_digit) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
         rem_in = rem_ff - 1'b1;
      end
      if (cmd.emit_prefix) begin
         char_in   = bda_pkg::CHAR_PREFIX;
         last_in   = 1'b0;
         strobe_in = 1'b1;
      end
      if (cmd.emit_digit) begin
         char_in   = bda_pkg::CHAR_ZERO + {4'd0, top_digit};
         last_in   = sts.one_left;
         strobe_in = 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   // status back to the controller
   assign sts.conv_done = (cnt_ff == '0);
   assign sts.top_zero  = (top_digit == 4'd0);
   assign sts.one_left  = (rem_ff == REM_W'(1));

   assign rsp_strobe    = strobe_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

`ifndef SYNTHESIS
   a_digit_left: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> rem_ff != '0)
      else $error("digit emitted with no digit left");
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.skip |-> (top_digit == 4'd0) && !sts.one_left)
      else $error("skipped a significant digit");
   a_prefix_out: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_prefix |=> rsp_strobe && !rsp_last_char && rsp_out_char == bda_pkg::CHAR_PREFIX)
      else $error("prefix word not presented");
`endif

endmodule

`default_nettype wire

// File: rtl/bda_controller.sv
`default_nettype none

module bda_controller (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  bda_pkg::status_type   sts,
   output bda_pkg::cmd_type      cmd
);

   bda_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         bda_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = bda_pkg::ST_CONVERT;
            end
         end
         bda_pkg::ST_CONVERT: begin
            cmd.convert = 1'b1;
            if (sts.conv_done) begin
               state_in = bda_pkg::ST_SKIP;
            end
         end
         bda_pkg::ST_SKIP: begin
            if (sts.top_zero && !sts.one_left) begin
               cmd.skip = 1'b1;
            end else begin
               state_in = bda_pkg::ST_PREFIX;
            end
         end
         bda_pkg::ST_PREFIX: begin
            cmd.emit_prefix = 1'b1;
            state_in        = bda_pkg::ST_DIGIT;
         end
         bda_pkg::ST_DIGIT: begin
            cmd.emit_digit = 1'b1;
            if (sts.one_left) begin
               state_in = bda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bda_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != bda_pkg::ST_IDLE);

`ifndef SYNTHESIS
   a_prefix_then_digit: assert property (@(posedge clock) disable iff (reset)
      state_ff == bda_pkg::ST_PREFIX |=> state_ff == bda_pkg::ST_DIGIT)
      else $error("prefix not followed by digits");
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == bda_pkg::ST_CONVERT)
      else $error("accepted word did not start conversion");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");
`endif

endmodule

`default_nettype wire

// File: rtl/binary_to_decimal_ascii.sv
// Channel   Ports                                        Handshake
// -------   ------------------------------------------   -----------------------------
// request   req_value[63:0]                              start && !busy accepts word
// result    rsp_out_char[7:0], rsp_last_char             rsp_strobe, one cycle, no stall
//
// Sequence: after the accepting edge busy stays high through the shift-and-add-3 step for
// every value bit, a scan that drops each leading zero digit, the 'r' word and one word
// per digit. Each word shows in the cycle after its state, so the last digit is shown in the
// first cycle with busy low and the next word can be accepted at the edge that ends it.
// Reset is synchronous and active high; it clears the controller and the result strobe.
// The receiver cannot stall: each result word is shown for exactly one cycle.
`default_nettype none

module binary_to_decimal_ascii #(
   parameter int VALUE_WIDTH = bda_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire [63:0]  req_value,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_char
);

   bda_pkg::cmd_type    cmd;
   bda_pkg::status_type sts;

   // sequencer
   bda_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // BCD shifter and character output
   bda_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

`default_nettype wire
